// ----- src/mxae_pkg.sv -----
package mxae_pkg;

    // Geometry and element width.
    localparam int DIM        = 4;
    localparam int ELEM_BITS  = 16;
    localparam int IDX_W      = $clog2(DIM);
    localparam int NUM_ELEM   = DIM * DIM;
    localparam int ADDR_W     = $clog2(NUM_ELEM);

    // Port field widths.
    localparam int OPC_W      = 3;
    localparam int POS_W      = 2;
    localparam int VAL_W      = 16;
    localparam int MAT_W      = 2;
    localparam int OUT_W      = 34;

    // Multiply datapath widths.
    localparam int PROD_W     = 2 * ELEM_BITS;
    localparam int ACC_W      = PROD_W + $clog2(DIM);
    localparam int SAT_W      = (ACC_W > OUT_W) ? ACC_W : OUT_W;

    // Queue depths.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic signed [ELEM_BITS:0] ELEM_MAX = {2'b00, {(ELEM_BITS-1){1'b1}}};

    typedef logic signed [ELEM_BITS-1:0] t_elem;

    typedef enum logic [OPC_W-1:0] {
        OPC_LOAD_A = 3'd0,
        OPC_LOAD_B = 3'd1,
        OPC_MUL    = 3'd2,
        OPC_ADD    = 3'd3,
        OPC_SUB    = 3'd4,
        OPC_SUBMIN = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        K_LOAD_A,
        K_LOAD_B,
        K_MUL,
        K_ADD,
        K_SUB,
        K_SUBMIN
    } t_kind;

    typedef enum logic [MAT_W-1:0] {
        MAT_A   = 2'd0,
        MAT_B   = 2'd1,
        MAT_RES = 2'd2
    } t_mat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_SUB,
        ST_SCAN,
        ST_SHIFT_A,
        ST_EMIT_B
    } t_state;

    typedef enum logic [2:0] {
        DP_MUL,
        DP_ADD,
        DP_SUB,
        DP_SCAN,
        DP_SHIFT_A,
        DP_PASS_B
    } t_dp;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        t_elem             elem;
    } t_cmd;

    typedef struct packed {
        logic              emit;
        t_dp               dp;
        logic              k_first;
        logic              k_last;
        logic [ADDR_W-1:0] addr;
        t_mat              mat;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic              last;
    } t_tag;

    typedef struct packed {
        t_mat                     mat;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic signed [OUT_W-1:0]  value;
        logic                     last;
    } t_out;

    // Keep the low ELEM_BITS bits of a loaded value as a signed element.
    function automatic t_elem to_elem(input logic signed [VAL_W-1:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        return w[ELEM_BITS-1:0];
    endfunction

    // Clip a dot product to the output range.
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] acc);
        logic signed [SAT_W-1:0] x;
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        x  = SAT_W'(acc);
        hi = SAT_W'(OUT_MAX);
        lo = SAT_W'(OUT_MIN);
        if (x > hi) begin
            return OUT_MAX;
        end else if (x < lo) begin
            return OUT_MIN;
        end
        return x[OUT_W-1:0];
    endfunction

    // Element minus the minimum, clipped at the largest element value.
    function automatic t_elem sub_min(input t_elem a, input t_elem m);
        logic signed [ELEM_BITS:0] d;
        d = (ELEM_BITS+1)'(a) - (ELEM_BITS+1)'(m);
        if (d > ELEM_MAX) begin
            return ELEM_MAX[ELEM_BITS-1:0];
        end
        return d[ELEM_BITS-1:0];
    endfunction

endpackage

// ----- src/mxae_front.sv -----
module mxae_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [mxae_pkg::OPC_W-1:0]           i_opcode,
    input  logic [mxae_pkg::POS_W-1:0]           i_row,
    input  logic [mxae_pkg::POS_W-1:0]           i_col,
    input  logic signed [mxae_pkg::VAL_W-1:0]    i_value,
    output logic                                 o_push,
    output mxae_pkg::t_cmd                       o_cmd,
    input  logic                                 i_full
);

    logic           r_valid;
    logic           n_valid;
    mxae_pkg::t_cmd r_cmd;
    mxae_pkg::t_cmd dec_cmd;
    logic           dec_keep;
    logic           in_range;
    logic           accept;

    // Decode the opcode; unused opcodes and loads outside the matrix are dropped here.
    always_comb begin
        in_range        = (int'(i_row) < mxae_pkg::DIM) && (int'(i_col) < mxae_pkg::DIM);
        dec_cmd.addr    = mxae_pkg::ADDR_W'(int'(i_row) * mxae_pkg::DIM + int'(i_col));
        dec_cmd.elem    = mxae_pkg::to_elem(i_value);
        dec_cmd.kind    = mxae_pkg::K_LOAD_A;
        dec_keep        = 1'b0;
        case (i_opcode)
            mxae_pkg::OPC_LOAD_A: begin
                dec_cmd.kind = mxae_pkg::K_LOAD_A;
                dec_keep     = in_range;
            end
            mxae_pkg::OPC_LOAD_B: begin
                dec_cmd.kind = mxae_pkg::K_LOAD_B;
                dec_keep     = in_range;
            end
            mxae_pkg::OPC_MUL: begin
                dec_cmd.kind = mxae_pkg::K_MUL;
                dec_keep     = 1'b1;
            end
            mxae_pkg::OPC_ADD: begin
                dec_cmd.kind = mxae_pkg::K_ADD;
                dec_keep     = 1'b1;
            end
            mxae_pkg::OPC_SUB: begin
                dec_cmd.kind = mxae_pkg::K_SUB;
                dec_keep     = 1'b1;
            end
            mxae_pkg::OPC_SUBMIN: begin
                dec_cmd.kind = mxae_pkg::K_SUBMIN;
                dec_keep     = 1'b1;
            end
            default: begin
                dec_keep     = 1'b0;
            end
        endcase
    end

    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_valid = r_valid && !o_push;
        if (accept && dec_keep) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && dec_keep) begin
            r_cmd <= dec_cmd;
        end
    end

endmodule

// ----- src/mxae_cmdq.sv -----
module mxae_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mxae_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_head_valid,
    output mxae_pkg::t_cmd o_head
);

    mxae_pkg::t_cmd                   r_mem [mxae_pkg::CMDQ_DEPTH];
    logic [mxae_pkg::CMDQ_PTR_W-1:0]  r_wr;
    logic [mxae_pkg::CMDQ_PTR_W-1:0]  r_rd;
    logic [mxae_pkg::CMDQ_PTR_W:0]    r_cnt;
    logic                             do_push;
    logic                             do_pop;

    assign o_full       = (r_cnt == (mxae_pkg::CMDQ_PTR_W+1)'(mxae_pkg::CMDQ_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ----- src/mxae_exec.sv -----
module mxae_exec (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  mxae_pkg::t_cmd i_head,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output mxae_pkg::t_out o_item
);

    // Sequencer.
    mxae_pkg::t_state               r_state;
    mxae_pkg::t_state               n_state;
    logic [mxae_pkg::IDX_W-1:0]     r_row;
    logic [mxae_pkg::IDX_W-1:0]     r_col;
    logic [mxae_pkg::IDX_W-1:0]     r_k;
    logic [mxae_pkg::IDX_W-1:0]     n_row;
    logic [mxae_pkg::IDX_W-1:0]     n_col;
    logic [mxae_pkg::IDX_W-1:0]     n_k;
    logic                           row_last;
    logic                           col_last;
    logic                           k_last;
    logic                           elem_last;
    logic                           credit_ok;
    logic                           iss_valid;
    mxae_pkg::t_tag                 iss_tag;
    logic [mxae_pkg::ADDR_W-1:0]    addr_a;
    logic [mxae_pkg::ADDR_W-1:0]    addr_b;
    logic                           ld_we_a;
    logic                           ld_we_b;

    // Matrix stores.
    mxae_pkg::t_elem                r_mem_a [mxae_pkg::NUM_ELEM];
    mxae_pkg::t_elem                r_mem_b [mxae_pkg::NUM_ELEM];
    logic [mxae_pkg::NUM_ELEM-1:0]  r_vld_a;
    logic [mxae_pkg::NUM_ELEM-1:0]  r_vld_b;
    logic                           we_a;
    logic                           we_b;
    logic [mxae_pkg::ADDR_W-1:0]    wa_a;
    logic [mxae_pkg::ADDR_W-1:0]    wa_b;
    mxae_pkg::t_elem                wd_a;
    mxae_pkg::t_elem                wd_b;

    // Read data stage.
    logic                           r_d_valid;
    mxae_pkg::t_tag                 r_d_tag;
    mxae_pkg::t_elem                r_a_q;
    mxae_pkg::t_elem                r_b_q;
    mxae_pkg::t_elem                r_min;
    mxae_pkg::t_elem                n_min;
    mxae_pkg::t_elem                mn_ab;
    mxae_pkg::t_elem                sh_a;
    mxae_pkg::t_elem                sh_b;
    logic signed [mxae_pkg::PROD_W-1:0] d_prod;
    logic signed [mxae_pkg::OUT_W-1:0]  d_val;
    logic                           wb_we;

    // Product / result stage.
    logic                           r_p_valid;
    mxae_pkg::t_tag                 r_p_tag;
    logic signed [mxae_pkg::OUT_W-1:0]  r_p_val;
    logic signed [mxae_pkg::PROD_W-1:0] r_p_prod;
    logic signed [mxae_pkg::ACC_W-1:0]  r_acc;
    logic signed [mxae_pkg::ACC_W-1:0]  acc_base;
    logic signed [mxae_pkg::ACC_W-1:0]  acc_sum;
    logic                           ob_push;
    mxae_pkg::t_out                 ob_data;

    // Output buffer.
    mxae_pkg::t_out                 r_ob [mxae_pkg::OBUF_DEPTH];
    logic [mxae_pkg::OBUF_PTR_W-1:0] r_ob_wr;
    logic [mxae_pkg::OBUF_PTR_W-1:0] r_ob_rd;
    logic [mxae_pkg::OBUF_PTR_W:0]   r_ob_cnt;
    logic                           ob_pop;

    assign row_last  = (r_row == mxae_pkg::IDX_W'(mxae_pkg::DIM - 1));
    assign col_last  = (r_col == mxae_pkg::IDX_W'(mxae_pkg::DIM - 1));
    assign k_last    = (r_k == mxae_pkg::IDX_W'(mxae_pkg::DIM - 1));
    assign elem_last = row_last && col_last;

    // Room for the two items in the pipe plus the one being issued.
    assign credit_ok = (r_ob_cnt <= (mxae_pkg::OBUF_PTR_W+1)'(mxae_pkg::OBUF_DEPTH - 3));

    always_comb begin
        n_state         = r_state;
        n_row           = r_row;
        n_col           = r_col;
        n_k             = r_k;
        o_pop           = 1'b0;
        ld_we_a         = 1'b0;
        ld_we_b         = 1'b0;
        iss_valid       = 1'b0;
        addr_a          = mxae_pkg::ADDR_W'(int'(r_row) * mxae_pkg::DIM + int'(r_col));
        addr_b          = addr_a;
        iss_tag         = '0;
        iss_tag.dp      = mxae_pkg::DP_ADD;
        iss_tag.mat     = mxae_pkg::MAT_RES;
        iss_tag.row     = mxae_pkg::POS_W'(r_row);
        iss_tag.col     = mxae_pkg::POS_W'(r_col);
        iss_tag.k_first = (r_row == '0) && (r_col == '0);
        iss_tag.k_last  = k_last;

        case (r_state)
            mxae_pkg::ST_IDLE: begin
                if (i_head_valid) begin
                    o_pop = 1'b1;
                    n_row = '0;
                    n_col = '0;
                    n_k   = '0;
                    case (i_head.kind)
                        mxae_pkg::K_LOAD_A: ld_we_a = 1'b1;
                        mxae_pkg::K_LOAD_B: ld_we_b = 1'b1;
                        mxae_pkg::K_MUL:    n_state = mxae_pkg::ST_MUL;
                        mxae_pkg::K_ADD:    n_state = mxae_pkg::ST_ADD;
                        mxae_pkg::K_SUB:    n_state = mxae_pkg::ST_SUB;
                        mxae_pkg::K_SUBMIN: n_state = mxae_pkg::ST_SCAN;
                        default:            n_state = mxae_pkg::ST_IDLE;
                    endcase
                end
            end
            default: begin
                if (credit_ok) begin
                    iss_valid = 1'b1;
                    if (r_state == mxae_pkg::ST_MUL) begin
                        addr_a          = mxae_pkg::ADDR_W'(int'(r_row) * mxae_pkg::DIM
                                                            + int'(r_k));
                        addr_b          = mxae_pkg::ADDR_W'(int'(r_k) * mxae_pkg::DIM
                                                            + int'(r_col));
                        iss_tag.dp      = mxae_pkg::DP_MUL;
                        iss_tag.emit    = k_last;
                        iss_tag.k_first = (r_k == '0);
                        iss_tag.last    = k_last && elem_last;
                    end else begin
                        iss_tag.emit = 1'b1;
                        iss_tag.last = elem_last;
                        case (r_state)
                            mxae_pkg::ST_ADD: iss_tag.dp = mxae_pkg::DP_ADD;
                            mxae_pkg::ST_SUB: iss_tag.dp = mxae_pkg::DP_SUB;
                            mxae_pkg::ST_SCAN: begin
                                iss_tag.dp   = mxae_pkg::DP_SCAN;
                                iss_tag.emit = 1'b0;
                                iss_tag.last = 1'b0;
                            end
                            mxae_pkg::ST_SHIFT_A: begin
                                iss_tag.dp   = mxae_pkg::DP_SHIFT_A;
                                iss_tag.mat  = mxae_pkg::MAT_A;
                                iss_tag.last = 1'b0;
                            end
                            default: begin
                                iss_tag.dp  = mxae_pkg::DP_PASS_B;
                                iss_tag.mat = mxae_pkg::MAT_B;
                            end
                        endcase
                    end

                    // Step through k (multiply only), then columns, then rows.
                    if ((r_state == mxae_pkg::ST_MUL) && !k_last) begin
                        n_k = r_k + 1'b1;
                    end else begin
                        n_k = '0;
                        if (col_last) begin
                            n_col = '0;
                            n_row = row_last ? '0 : r_row + 1'b1;
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                        if (elem_last) begin
                            case (r_state)
                                mxae_pkg::ST_SCAN:    n_state = mxae_pkg::ST_SHIFT_A;
                                mxae_pkg::ST_SHIFT_A: n_state = mxae_pkg::ST_EMIT_B;
                                default:              n_state = mxae_pkg::ST_IDLE;
                            endcase
                        end
                    end
                end
                iss_tag.addr = addr_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mxae_pkg::ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
        end
    end

    // Write port: loads from the sequencer, write-back from the minimum shift.
    assign wb_we = r_d_valid && (r_d_tag.dp == mxae_pkg::DP_SHIFT_A);
    assign we_a  = ld_we_a || wb_we;
    assign we_b  = ld_we_b || wb_we;
    assign wa_a  = ld_we_a ? i_head.addr : r_d_tag.addr;
    assign wa_b  = ld_we_b ? i_head.addr : r_d_tag.addr;
    assign wd_a  = ld_we_a ? i_head.elem : sh_a;
    assign wd_b  = ld_we_b ? i_head.elem : sh_b;

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_mem_a[wa_a] <= wd_a;
        end
        if (we_b) begin
            r_mem_b[wa_b] <= wd_b;
        end
        r_a_q <= r_vld_a[addr_a] ? r_mem_a[addr_a] : '0;
        r_b_q <= r_vld_b[addr_b] ? r_mem_b[addr_b] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= '0;
            r_vld_b <= '0;
        end else begin
            if (we_a) begin
                r_vld_a[wa_a] <= 1'b1;
            end
            if (we_b) begin
                r_vld_b[wa_b] <= 1'b1;
            end
        end
    end

    // Read data stage.
    assign d_prod = r_a_q * r_b_q;
    assign sh_a   = mxae_pkg::sub_min(r_a_q, r_min);
    assign sh_b   = mxae_pkg::sub_min(r_b_q, r_min);
    assign mn_ab  = (r_a_q < r_b_q) ? r_a_q : r_b_q;

    always_comb begin
        n_min = r_min;
        if (r_d_valid && (r_d_tag.dp == mxae_pkg::DP_SCAN)) begin
            if (r_d_tag.k_first || (mn_ab < r_min)) begin
                n_min = mn_ab;
            end
        end
    end

    always_comb begin
        case (r_d_tag.dp)
            mxae_pkg::DP_ADD:     d_val = mxae_pkg::OUT_W'(r_a_q) + mxae_pkg::OUT_W'(r_b_q);
            mxae_pkg::DP_SUB:     d_val = mxae_pkg::OUT_W'(r_a_q) - mxae_pkg::OUT_W'(r_b_q);
            mxae_pkg::DP_SHIFT_A: d_val = mxae_pkg::OUT_W'(sh_a);
            mxae_pkg::DP_PASS_B:  d_val = mxae_pkg::OUT_W'(r_b_q);
            default:              d_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_p_valid <= 1'b0;
        end else begin
            r_d_valid <= iss_valid;
            r_p_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_tag  <= iss_tag;
        r_min    <= n_min;
        r_p_tag  <= r_d_tag;
        r_p_val  <= d_val;
        r_p_prod <= d_prod;
        if (r_p_valid && (r_p_tag.dp == mxae_pkg::DP_MUL)) begin
            r_acc <= acc_sum;
        end
    end

    // Product / result stage: accumulate the dot product, then queue the result.
    always_comb begin
        if (r_p_tag.k_first) begin
            acc_base = '0;
        end else begin
            acc_base = r_acc;
        end
        acc_sum = acc_base + mxae_pkg::ACC_W'(r_p_prod);
    end

    assign ob_push       = r_p_valid && r_p_tag.emit;
    assign ob_data.mat   = r_p_tag.mat;
    assign ob_data.row   = r_p_tag.row;
    assign ob_data.col   = r_p_tag.col;
    assign ob_data.last  = r_p_tag.last;
    assign ob_data.value = (r_p_tag.dp == mxae_pkg::DP_MUL) ? mxae_pkg::sat_out(acc_sum)
                                                             : r_p_val;

    // Output buffer.
    assign o_valid = (r_ob_cnt != '0);
    assign o_item  = r_ob[r_ob_rd];
    assign ob_pop  = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wr  <= '0;
            r_ob_rd  <= '0;
            r_ob_cnt <= '0;
        end else begin
            if (ob_push) begin
                r_ob_wr <= r_ob_wr + 1'b1;
            end
            if (ob_pop) begin
                r_ob_rd <= r_ob_rd + 1'b1;
            end
            if (ob_push && !ob_pop) begin
                r_ob_cnt <= r_ob_cnt + 1'b1;
            end else if (ob_pop && !ob_push) begin
                r_ob_cnt <= r_ob_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ob_push) begin
            r_ob[r_ob_wr] <= ob_data;
        end
    end

endmodule

// ----- src/matrix4x4_arith_engine.sv -----
// Two 4x4 signed matrices, A and B, are held in the block and cleared to zero at reset.
// Load items write one element each and return nothing; multiply, add and subtract
// return the 16 elements of the result in row-major order, and subtract-minimum
// shifts both matrices down by their common minimum (clipped at the largest element
// value), stores them back and returns A then B as 32 items; the last flag marks the
// final item of each run. Items are decoded into a front register and passed on to a
// four-entry command queue, so up to five items can wait behind a running command
// before the input stalls. While idle, the back end takes one command from the queue
// per cycle, and a load is written to its matrix as it is taken. It reads each matrix
// through a single read port, one element per cycle while the output buffer has room:
// add and subtract read each element once, multiply does one multiply-accumulate per
// element read, four per result element, and subtract-minimum runs a minimum scan, a
// shift and write-back of both matrices, and a re-read of B. Each result passes the
// read data stage and the product/result stage before it is written to the output
// buffer and offered. Results wait in a four-entry output buffer, and the back end
// pauses whenever that buffer holds two or more results, so a stalled output slows
// the run down without losing anything.
module matrix4x4_arith_engine (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [mxae_pkg::OPC_W-1:0]           i_opcode,
    input  logic [mxae_pkg::POS_W-1:0]           i_row,
    input  logic [mxae_pkg::POS_W-1:0]           i_col,
    input  logic signed [mxae_pkg::VAL_W-1:0]    i_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [mxae_pkg::MAT_W-1:0]           o_out_matrix,
    output logic [mxae_pkg::POS_W-1:0]           o_out_row,
    output logic [mxae_pkg::POS_W-1:0]           o_out_col,
    output logic signed [mxae_pkg::OUT_W-1:0]    o_out_value,
    output logic                                 o_last
);

    logic           q_push;
    mxae_pkg::t_cmd q_cmd;
    logic           q_full;
    logic           q_pop;
    logic           q_head_valid;
    mxae_pkg::t_cmd q_head;
    mxae_pkg::t_out out_item;

    // The front stage decodes each item and drops unused opcodes.
    mxae_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_opcode (i_opcode),
        .i_row    (i_row),
        .i_col    (i_col),
        .i_value  (i_value),
        .o_push   (q_push),
        .o_cmd    (q_cmd),
        .i_full   (q_full)
    );

    // The queue keeps commands in order, so a load never overtakes a compute run.
    mxae_cmdq u_cmdq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_cmd        (q_cmd),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    // The back end owns both matrix stores and runs the arithmetic.
    mxae_exec u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_item       (out_item)
    );

    assign o_out_matrix = out_item.mat;
    assign o_out_row    = out_item.row;
    assign o_out_col    = out_item.col;
    assign o_out_value  = out_item.value;
    assign o_last       = out_item.last;

    // The front stage never offers a command to a full queue.
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    // The back end only takes a command that is present.
    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_head_valid)
        else $error("command popped from an empty queue");

    // Reset empties the output buffer.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered straight after reset");

    // A run never ends on an element of matrix A.
    a_last_not_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_out_matrix != mxae_pkg::MAT_A))
        else $error("last flag set on an element of matrix A");

endmodule
